// ----- rtl/core/bounded_byte_fifo_with_eof_defines.svh -----
// assertion macros shared by the byte fifo modules
`ifndef BOUNDED_BYTE_FIFO_WITH_EOF_DEFINES_SVH
`define BOUNDED_BYTE_FIFO_WITH_EOF_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbf check failed");

// next-cycle implication, checked outside reset
`define BBF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbf check failed");

`endif

// ----- rtl/core/bbf_pkg.sv -----
// shared constants, command codes and control structs for the byte fifo
`default_nettype none

package bbf_pkg;

   localparam int DEPTH     = 1024;
   localparam int MAX_BURST = 64;
   localparam int CAP_RESET = 1024;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int LEVEL_W = 11;
   localparam int TOTAL_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 3'd0,
      CMD_READ  = 3'd1,
      CMD_PEEK  = 3'd2,
      CMD_POP   = 3'd3,
      CMD_END   = 3'd4
   } bbf_op_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic rd;
      logic emit_byte;
      logic emit_status;
   } bbf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic burst;
      logic slot_free;
      logic last_byte;
   } bbf_sts_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               write_accepted;
      logic               last;
      logic [LEVEL_W-1:0] fill_level;
      logic [LEVEL_W-1:0] space_left;
      logic               input_done;
      logic               at_eof;
      logic [TOTAL_W-1:0] total_written;
      logic [TOTAL_W-1:0] total_read;
   } bbf_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/bbf_if.sv -----
// request and response channel interfaces of the byte fifo
`default_nettype none

interface bbf_req_if import bbf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [BYTE_W-1:0]  write_byte;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output cmd, output write_byte, output count, input ready);
   modport sink   (input valid, input cmd, input write_byte, input count, output ready);
endinterface

interface bbf_rsp_if import bbf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               byte_valid;
   logic               write_accepted;
   logic               last;
   logic [LEVEL_W-1:0] fill_level;
   logic [LEVEL_W-1:0] space_left;
   logic               input_done;
   logic               at_eof;
   logic [TOTAL_W-1:0] total_written;
   logic [TOTAL_W-1:0] total_read;

   modport source (output valid, output out_byte, output byte_valid, output write_accepted,
                   output last, output fill_level, output space_left, output input_done,
                   output at_eof, output total_written, output total_read, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input write_accepted,
                   input last, input fill_level, input space_left, input input_done,
                   input at_eof, input total_written, input total_read, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bbf_ctrl.sv -----
// sequencing state machine of the byte fifo
`default_nettype none
`include "bounded_byte_fifo_with_eof_defines.svh"

module bbf_ctrl import bbf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire bbf_sts_type sts,
   output bbf_cmd_type      ctl
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_READ = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_STAT = 5'b10000
   } bbf_state_type;

   bbf_state_type state_ff;
   bbf_state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.burst ? ST_READ : ST_STAT;
         end
         ST_READ: begin
            ctl.rd   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               ctl.emit_byte = 1'b1;
               state_in      = sts.last_byte ? ST_IDLE : ST_READ;
            end
         end
         ST_STAT: begin
            if (sts.slot_free) begin
               ctl.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BBF_ASSERT_NXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)

endmodule

`default_nettype wire

// ----- rtl/core/bbf_dp.sv -----
// byte store, pointers, counters and result register of the byte fifo
`default_nettype none
`include "bounded_byte_fifo_with_eof_defines.svh"

module bbf_dp import bbf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [LEVEL_W-1:0] csr_wdata,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [BYTE_W-1:0]  req_write_byte,
   input  wire logic [COUNT_W-1:0] req_count,
   input  wire logic               rsp_ready,
   input  wire bbf_cmd_type        ctl,
   output bbf_sts_type             sts,
   output logic                    rsp_valid,
   output bbf_rsp_type             rsp_data
);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [COUNT_W-1:0] k);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + (PTR_W+1)'(k);
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [BYTE_W-1:0] mem [DEPTH];

   logic [LEVEL_W-1:0] capacity_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [BYTE_W-1:0]  wbyte_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [LEVEL_W-1:0] held_ff, held_in;
   logic               ended_ff, ended_in;
   logic [TOTAL_W-1:0] wtot_ff, wtot_in;
   logic [TOTAL_W-1:0] rtot_ff, rtot_in;
   logic [PTR_W-1:0]   bp_ff, bp_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic               acc_ff, acc_in;
   logic [BYTE_W-1:0]  mem_q_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bbf_rsp_type        rsp_ff, rsp_in;

   logic [LEVEL_W-1:0] eff_cap;
   logic [LEVEL_W-1:0] space;
   logic [COUNT_W-1:0] cnt_sat;
   logic [COUNT_W-1:0] n;
   logic               is_write, is_read, is_peek, is_pop, is_end;
   logic               do_write, do_remove, load;
   logic [PTR_W:0]     chk_sum;
   logic [PTR_W-1:0]   chk_tail;

   assign eff_cap = (capacity_ff > LEVEL_W'(DEPTH)) ? LEVEL_W'(DEPTH) : capacity_ff;
   assign space   = (held_ff >= eff_cap) ? '0 : eff_cap - held_ff;
   assign cnt_sat = (count_ff > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : count_ff;
   assign n       = (LEVEL_W'(cnt_sat) < held_ff) ? cnt_sat : COUNT_W'(held_ff);

   assign is_write = (cmd_ff == CMD_WRITE);
   assign is_read  = (cmd_ff == CMD_READ);
   assign is_peek  = (cmd_ff == CMD_PEEK);
   assign is_pop   = (cmd_ff == CMD_POP);
   assign is_end   = (cmd_ff == CMD_END);

   assign do_write  = ctl.exec && is_write && (space != '0);
   assign do_remove = ctl.exec && (is_read || is_pop);
   assign load      = ctl.emit_byte || ctl.emit_status;

   assign sts.burst     = (is_read || is_peek) && (n != '0);
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;
   assign sts.last_byte = (rem_ff == COUNT_W'(1));

   always_comb begin
      head_in  = do_remove ? ptr_add(head_ff, n) : head_ff;
      tail_in  = do_write ? ptr_inc(tail_ff) : tail_ff;
      held_in  = held_ff;
      if (do_write) begin
         held_in = held_ff + LEVEL_W'(1);
      end else if (do_remove) begin
         held_in = held_ff - LEVEL_W'(n);
      end
      wtot_in  = do_write ? wtot_ff + TOTAL_W'(1) : wtot_ff;
      rtot_in  = do_remove ? rtot_ff + TOTAL_W'(n) : rtot_ff;
      ended_in = ended_ff || (ctl.exec && is_end);
      acc_in   = ctl.exec ? do_write : acc_ff;
      bp_in    = bp_ff;
      rem_in   = rem_ff;
      if (ctl.exec) begin
         bp_in  = head_ff;
         rem_in = n;
      end else if (ctl.emit_byte) begin
         bp_in  = ptr_inc(bp_ff);
         rem_in = rem_ff - COUNT_W'(1);
      end
   end

   // result fields; status is already the after-step state
   always_comb begin
      rsp_in.out_byte       = ctl.emit_byte ? mem_q_ff : '0;
      rsp_in.byte_valid     = ctl.emit_byte;
      rsp_in.write_accepted = ctl.emit_status && acc_ff;
      rsp_in.last           = ctl.emit_status || sts.last_byte;
      rsp_in.fill_level     = held_ff;
      rsp_in.space_left     = space;
      rsp_in.input_done     = ended_ff;
      rsp_in.at_eof         = ended_ff && (held_ff == '0);
      rsp_in.total_written  = wtot_ff;
      rsp_in.total_read     = rtot_ff;
      rsp_valid_in          = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= LEVEL_W'(CAP_RESET);
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         ended_ff     <= 1'b0;
         wtot_ff      <= '0;
         rtot_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         ended_ff     <= ended_in;
         wtot_ff      <= wtot_in;
         rtot_ff      <= rtot_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff   <= req_cmd;
         wbyte_ff <= req_write_byte;
         count_ff <= req_count;
      end
      bp_ff  <= bp_in;
      acc_ff <= acc_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[tail_ff] <= wbyte_ff;
      end
      if (ctl.rd) begin
         mem_q_ff <= mem[bp_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // tail must sit exactly held bytes past head
   assign chk_sum  = {1'b0, head_ff} + (PTR_W+1)'(held_ff);
   assign chk_tail = (chk_sum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(chk_sum - (PTR_W+1)'(DEPTH))
                                                    : chk_sum[PTR_W-1:0];

   `BBF_ASSERT_IMP(a_held_max, clock, reset, 1'b1, held_ff <= LEVEL_W'(DEPTH))
   `BBF_ASSERT_IMP(a_ptr_gap, clock, reset, 1'b1, chk_tail == tail_ff)
   `BBF_ASSERT_IMP(a_emit_rem, clock, reset, ctl.emit_byte, rem_ff != '0)

endmodule

`default_nettype wire

// ----- rtl/core/bounded_byte_fifo_with_eof.sv -----
// top level of the bounded byte fifo with end-of-input flag
//
//   channel  | direction | handshake        | contents
//   ---------+-----------+------------------+-----------------------------------------
//   req_ch   | in        | valid / ready    | cmd, write_byte, count
//   rsp_ch   | out       | valid / ready    | byte, flags, level, space, totals
//   csr_*    | in        | write enable     | capacity (11 bits)
//
// write, end input, pop and unknown commands: accept, execute, then post one status result
// read and peek: accept, execute, then per byte a store read and an emit; if none, status
// the byte store is a single-port 1024 x 8 memory with registered read data
// reset is synchronous and clears pointers, level, totals and flag; the store is not cleared
// a result waiting in the output register does not block acceptance of the next request
// a stalled response only holds the sequencer when a new result must be loaded
`default_nettype none

module bounded_byte_fifo_with_eof import bbf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   bbf_req_if.sink                 req_ch,
   bbf_rsp_if.source               rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [LEVEL_W-1:0] csr_wdata
);

   // control and status between sequencer and datapath
   bbf_cmd_type ctl;
   bbf_sts_type sts;
   bbf_rsp_type rsp_data;
   logic        req_ready;
   logic        rsp_valid;

   // sequencer: accept, execute, then stream bytes or post one status result
   bbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // datapath: byte store, head and tail, level, totals, output register
   bbf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_cmd        (req_ch.cmd),
      .req_write_byte (req_ch.write_byte),
      .req_count      (req_ch.count),
      .rsp_ready      (rsp_ch.ready),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

   assign req_ch.ready = req_ready;

   // response channel driven straight from the output register
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.out_byte       = rsp_data.out_byte;
   assign rsp_ch.byte_valid     = rsp_data.byte_valid;
   assign rsp_ch.write_accepted = rsp_data.write_accepted;
   assign rsp_ch.last           = rsp_data.last;
   assign rsp_ch.fill_level     = rsp_data.fill_level;
   assign rsp_ch.space_left     = rsp_data.space_left;
   assign rsp_ch.input_done     = rsp_data.input_done;
   assign rsp_ch.at_eof         = rsp_data.at_eof;
   assign rsp_ch.total_written  = rsp_data.total_written;
   assign rsp_ch.total_read     = rsp_data.total_read;

endmodule

`default_nettype wire
